// ===== sv/inversion_counter_defines.svh =====
// Assertion macros used by the verification checker of the inversion counter.
`ifndef INVERSION_COUNTER_DEFINES_SVH
`define INVERSION_COUNTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("inversion_counter check failed");

// The consequent must hold in the cycle after the antecedent.
`define IC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("inversion_counter check failed");

`endif

// ===== sv/ic_pkg.sv =====
package ic_pkg;

	localparam int unsigned ELEM_W  = 32;
	localparam int unsigned TOTAL_W = 13;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned SUM_W   = TOTAL_W + 1;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic signed [ELEM_W-1:0] value;
		logic                     is_last;
	} ic_in_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] inversion_count;
		logic [COUNT_W-1:0] element_count;
		logic               overflow;
	} ic_out_t;

	// Control that travels with each element along the chain.
	typedef struct packed {
		logic valid;
		logic last;
		logic drop;
	} ic_ctrl_t;

endpackage

// ===== sv/inversion_counter.sv =====
// Channel  | Handshake                  | Payload
// item     | item_valid / item_ready    | ic_in_t: value, is_last
// result   | result_valid / result_ready | ic_out_t: inversion_count, element_count, overflow
//
// One element is accepted per cycle unless a held result stalls the row; it walks the row of
// MAX_ELEMENTS cells, one cell a cycle. The tail registers the result from the list's last element.
// The row of cells and the result register advance together; a held result stalls all of them.
// Reset clears the fill count, the accumulators and every valid flag; stored elements are not cleared.
module inversion_counter #(
	parameter int unsigned MAX_ELEMENTS = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  ic_pkg::ic_in_t  item,
	output logic            result_valid,
	input  logic            result_ready,
	output ic_pkg::ic_out_t result
);
	import ic_pkg::*;

	localparam int unsigned IDX_W  = $clog2(MAX_ELEMENTS);
	localparam int unsigned FILL_W = $clog2(MAX_ELEMENTS + 1);

	logic                     advance;
	logic [FILL_W-1:0]        fill_q;
	logic                     drop;
	ic_ctrl_t                 ctrl_w  [MAX_ELEMENTS+1];
	logic signed [ELEM_W-1:0] value_w [MAX_ELEMENTS+1];
	logic [IDX_W-1:0]         idx_w   [MAX_ELEMENTS+1];
	logic [IDX_W-1:0]         cnt_w   [MAX_ELEMENTS+1];

	assign advance    = !result_valid || result_ready;
	assign item_ready = advance;
	assign drop       = (fill_q == FILL_W'(MAX_ELEMENTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (item_valid && advance) begin
			if (item.is_last) begin
				fill_q <= '0;
			end else if (!drop) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	assign ctrl_w[0]  = '{valid: item_valid, last: item.is_last, drop: drop};
	assign value_w[0] = item.value;
	assign idx_w[0]   = fill_q[IDX_W-1:0];
	assign cnt_w[0]   = '0;

	for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
		ic_cell #(
			.IDX_W (IDX_W),
			.INDEX (k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.ctrl_in   (ctrl_w[k]),
			.value_in  (value_w[k]),
			.idx_in    (idx_w[k]),
			.cnt_in    (cnt_w[k]),
			.ctrl_out  (ctrl_w[k+1]),
			.value_out (value_w[k+1]),
			.idx_out   (idx_w[k+1]),
			.cnt_out   (cnt_w[k+1])
		);
	end

	ic_tail #(
		.IDX_W  (IDX_W),
		.FILL_W (FILL_W)
	) u_tail (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.ctrl_in      (ctrl_w[MAX_ELEMENTS]),
		.cnt_in       (cnt_w[MAX_ELEMENTS]),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ===== sv/ic_cell.sv =====
module ic_cell #(
	parameter int unsigned IDX_W = 7,
	parameter int unsigned INDEX = 0
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             advance,
	input  ic_pkg::ic_ctrl_t                 ctrl_in,
	input  logic signed [ic_pkg::ELEM_W-1:0] value_in,
	input  logic [IDX_W-1:0]                 idx_in,
	input  logic [IDX_W-1:0]                 cnt_in,
	output ic_pkg::ic_ctrl_t                 ctrl_out,
	output logic signed [ic_pkg::ELEM_W-1:0] value_out,
	output logic [IDX_W-1:0]                 idx_out,
	output logic [IDX_W-1:0]                 cnt_out
);
	import ic_pkg::*;

	logic signed [ELEM_W-1:0] elem_q;
	ic_ctrl_t                 ctrl_q;
	logic signed [ELEM_W-1:0] value_q;
	logic [IDX_W-1:0]         idx_q;
	logic [IDX_W-1:0]         cnt_q;
	logic                     active;
	logic                     own;
	logic                     hit;

	assign active = ctrl_in.valid && !ctrl_in.drop;
	assign own    = active && (idx_in == IDX_W'(INDEX));
	assign hit    = active && (idx_in > IDX_W'(INDEX)) && (elem_q > value_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else if (advance) begin
			ctrl_q <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			value_q <= value_in;
			idx_q   <= idx_in;
			cnt_q   <= cnt_in + IDX_W'(hit);
			if (own) begin
				elem_q <= value_in;
			end
		end
	end

	assign ctrl_out  = ctrl_q;
	assign value_out = value_q;
	assign idx_out   = idx_q;
	assign cnt_out   = cnt_q;

endmodule

// ===== sv/ic_tail.sv =====
module ic_tail #(
	parameter int unsigned IDX_W  = 7,
	parameter int unsigned FILL_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  ic_pkg::ic_ctrl_t ctrl_in,
	input  logic [IDX_W-1:0] cnt_in,
	output logic             result_valid,
	output ic_pkg::ic_out_t  result
);
	import ic_pkg::*;

	logic [TOTAL_W-1:0]        total_q;
	logic [FILL_W-1:0]         count_q;
	logic                      ovf_q;
	logic                      valid_q;
	ic_out_t                   result_q;
	logic [SUM_W-1:0]          sum;
	logic [TOTAL_W-1:0]        total_nx;
	logic [FILL_W-1:0]         count_nx;
	logic [FILL_W+COUNT_W-1:0] count_ext;
	logic                      ovf_nx;

	always_comb begin
		sum = {1'b0, total_q} + SUM_W'(cnt_in);
		if (ctrl_in.drop) begin
			total_nx = total_q;
			count_nx = count_q;
		end else begin
			total_nx = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
			count_nx = count_q + FILL_W'(1);
		end
		ovf_nx    = ovf_q || ctrl_in.drop;
		count_ext = {{COUNT_W{1'b0}}, count_nx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= ctrl_in.valid && ctrl_in.last;
			if (ctrl_in.valid) begin
				if (ctrl_in.last) begin
					total_q <= '0;
					count_q <= '0;
					ovf_q   <= 1'b0;
				end else begin
					total_q <= total_nx;
					count_q <= count_nx;
					ovf_q   <= ovf_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ctrl_in.valid && ctrl_in.last) begin
			result_q.inversion_count <= total_nx;
			result_q.element_count   <= (count_ext > (FILL_W+COUNT_W)'(COUNT_MAX)) ?
				COUNT_MAX : count_ext[COUNT_W-1:0];
			result_q.overflow        <= ovf_nx;
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

endmodule

// ===== sv/ic_checker.sv =====
`include "inversion_counter_defines.svh"

module ic_checker #(
	parameter int unsigned MAX_ELEMENTS = 128
) (
	input logic            clk,
	input logic            arst_n,
	input logic            item_valid,
	input logic            item_ready,
	input ic_pkg::ic_in_t  item,
	input logic            result_valid,
	input logic            result_ready,
	input ic_pkg::ic_out_t result
);
	import ic_pkg::*;

	localparam int unsigned FULL_COUNT = (MAX_ELEMENTS > 255) ? 255 : MAX_ELEMENTS;

	logic [15:0] pair_limit;

	assign pair_limit = (16'(result.element_count) * (16'(result.element_count) - 16'd1)) >> 1;

	`IC_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid && $stable(result))
	`IC_ASSERT_NOW(a_ready_when_empty, !result_valid, item_ready)
	`IC_ASSERT_NOW(a_count_range, result_valid, (result.element_count != 8'd0) && (32'(result.element_count) <= MAX_ELEMENTS))
	`IC_ASSERT_NOW(a_pairs_bound, result_valid, 16'(result.inversion_count) <= pair_limit)
	`IC_ASSERT_NOW(a_overflow_full, result_valid && result.overflow, 32'(result.element_count) == FULL_COUNT)

endmodule

bind inversion_counter ic_checker #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_ic_checker (.*);
